/* sv/psm_pkg.sv */
// Package: shared constants, widths and types of the perspective screen mapper.
`timescale 1ns / 1ps
package psm_pkg;

  // Fixed point format and register widths
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 15;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int VAL_W     = 32;

  localparam logic [CFG_W-1:0] VP_W_RST = CFG_W'(1920);
  localparam logic [CFG_W-1:0] VP_H_RST = CFG_W'(1080);

  // tan(37.5 deg) scaled by 2^32
  localparam logic [31:0] K_Q32 = 32'd3295644319;

  // Datapath widths
  localparam int MO_W    = 32;                          // operand / depth magnitude
  localparam int MZK_W   = 63;                          // |z| * K
  localparam int MOH_W   = MO_W + CFG_W;                // |x| * H
  localparam int C_SH_W  = CFG_W + FRAC_BITS;           // viewport << FRAC
  localparam int A_W     = ((C_SH_W + 1 > 34) ? C_SH_W + 1 : 34) + 1;
  localparam int MA_W    = A_W - 1;
  localparam int PLO_W   = MA_W + 32;
  localparam int PHI_W   = MA_W + MZK_W - 32;
  localparam int P_W     = MA_W + MZK_W;
  localparam int SHA     = 31 + FRAC_BITS;
  localparam int SHB     = 32 + FRAC_BITS;
  localparam int NA_W    = MOH_W + SHA;
  localparam int N_W     = (P_W > NA_W) ? P_W : NA_W;
  localparam int DB_W    = CFG_W + SHB;
  localparam int D_W     = (DB_W > MZK_W) ? DB_W : MZK_W;
  localparam int Q_W     = (16 + FRAC_BITS > 33) ? 16 + FRAC_BITS : 33;
  localparam int NH_W    = N_W - Q_W;
  localparam int BASE_W  = CFG_W + FRAC_BITS - 1;
  localparam int RES_W   = Q_W + 2;

  typedef enum logic [2:0] {
    FN_X_TO_SCR = 3'd0,
    FN_SCR_TO_X = 3'd1,
    FN_Y_TO_SCR = 3'd2,
    FN_SCR_TO_Y = 3'd3,
    FN_HEIGHT   = 3'd4,
    FN_WIDTH    = 3'd5
  } func_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    logic              sp;     // forced zero result with error
    logic              tneg;   // quotient term is subtracted
    logic [BASE_W-1:0] base;   // half-viewport offset
  } ctl_t;

endpackage

/* sv/psm_if.sv */
// Interfaces: input and result channels of the perspective screen mapper.
`timescale 1ns / 1ps
interface psm_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        func;
  logic signed [psm_pkg::VAL_W-1:0]  operand;
  logic signed [psm_pkg::VAL_W-1:0]  depth_z;

  modport source (output valid, func, operand, depth_z, input ready);
  modport sink   (input valid, func, operand, depth_z, output ready);
endinterface

interface psm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [psm_pkg::VAL_W-1:0]  result;
  logic                              error;

  modport source (output valid, result, error, input ready);
  modport sink   (input valid, result, error, output ready);
endinterface

/* sv/perspective_screen_mapper_top.sv */
// Top level: pipelined view-space / screen coordinate mapper with APB registers.
`timescale 1ns / 1ps
// One item enters per clock while the result register is not stalled. The
// pipeline has four stages of sign handling, multiplication and operand forming, one
// overflow check, a 33-stage radix-2 restoring divider that yields one
// quotient bit per stage, and a final stage that adds the half-viewport
// offset and saturates. A stalled result register holds the whole pipeline.
// Viewport width and height live at byte addresses 0 and 4 and may only be
// written while no item is in flight.
module perspective_screen_mapper_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psm_pkg::ADDR_W-1:0]  paddr,
  input  logic [psm_pkg::DATA_W-1:0]  pwdata,
  output logic [psm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  psm_in_if.sink                      in_ch,
  psm_out_if.source                   out_ch
);
  import psm_pkg::*;

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(64'sd2147483647);
  localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] vp_w, vp_h;
  reg_idx_t         ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_w <= VP_W_RST;
      vp_h <= VP_H_RST;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_WIDTH:  vp_w <= pwdata[CFG_W-1:0];
        REG_HEIGHT: vp_h <= pwdata[CFG_W-1:0];
        default:    vp_w <= vp_w;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_WIDTH:  prdata = DATA_W'(vp_w);
      REG_HEIGHT: prdata = DATA_W'(vp_h);
      default:    prdata = '0;
    endcase
  end

  // ---------------- pipeline advance ----------------
  logic en;
  logic out_v;

  assign en          = !out_v || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage 1: signs, magnitudes, offsets ----------------
  func_t                   fn;
  logic                    so, sz, is_a, sa;
  logic [MO_W-1:0]         mo_c, mz_c;
  logic [CFG_W-1:0]        cb, ca;
  logic [C_SH_W-1:0]       cshift;
  logic signed [A_W-1:0]   opx, a_val;
  logic [MA_W-1:0]         ma_c;
  ctl_t                    ctl_c;

  always_comb begin
    fn     = func_t'(in_ch.func);
    so     = in_ch.operand[VAL_W-1];
    sz     = in_ch.depth_z[VAL_W-1];
    mo_c   = so ? MO_W'(-in_ch.operand) : MO_W'(in_ch.operand);
    mz_c   = sz ? MO_W'(-in_ch.depth_z) : MO_W'(in_ch.depth_z);
    is_a   = (fn == FN_X_TO_SCR) || (fn == FN_Y_TO_SCR);
    cb     = (fn == FN_SCR_TO_X) ? vp_w : (fn == FN_SCR_TO_Y) ? vp_h : '0;
    ca     = (fn == FN_X_TO_SCR) ? vp_w : vp_h;
    cshift = {cb, {FRAC_BITS{1'b0}}};
    opx    = A_W'(in_ch.operand);
    a_val  = (opx <<< 1) - signed'(A_W'(cshift));
    sa     = a_val[A_W-1];
    ma_c   = sa ? MA_W'(-a_val) : MA_W'(a_val);
    ctl_c.tneg = is_a ? (so ^ sz ^ (fn == FN_Y_TO_SCR)) : (sa ^ sz);
    ctl_c.base = is_a ? BASE_W'({ca, {(FRAC_BITS-1){1'b0}}}) : '0;
    unique case (fn)
      FN_X_TO_SCR, FN_Y_TO_SCR:
        ctl_c.sp = (in_ch.depth_z == '0);
      FN_SCR_TO_X, FN_SCR_TO_Y, FN_HEIGHT, FN_WIDTH:
        ctl_c.sp = (in_ch.depth_z == '0) || (vp_h == '0);
      default:
        ctl_c.sp = 1'b1;
    endcase
  end

  logic            v1, isa1;
  logic [MO_W-1:0] mo1, mz1;
  logic [MA_W-1:0] ma1;
  ctl_t            ctl1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      isa1 <= is_a;
      mo1  <= mo_c;
      mz1  <= mz_c;
      ma1  <= ma_c;
      ctl1 <= ctl_c;
    end
  end

  // ---------------- stage 2: |z|*K and |x|*H ----------------
  logic             v2, isa2;
  logic [MZK_W-1:0] mzk2;
  logic [MOH_W-1:0] moh2;
  logic [MA_W-1:0]  ma2;
  ctl_t             ctl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      isa2 <= isa1;
      mzk2 <= MZK_W'(64'(mz1) * 64'(K_Q32));
      moh2 <= MOH_W'(mo1) * MOH_W'(vp_h);
      ma2  <= ma1;
      ctl2 <= ctl1;
    end
  end

  // ---------------- stage 3: partial products of a*|z|*K ----------------
  logic             v3, isa3;
  logic [PLO_W-1:0] plo3;
  logic [PHI_W-1:0] phi3;
  logic [MZK_W-1:0] mzk3;
  logic [MOH_W-1:0] moh3;
  ctl_t             ctl3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      isa3 <= isa2;
      plo3 <= PLO_W'(ma2) * PLO_W'(mzk2[31:0]);
      phi3 <= PHI_W'(ma2) * PHI_W'(mzk2[MZK_W-1:32]);
      mzk3 <= mzk2;
      moh3 <= moh2;
      ctl3 <= ctl2;
    end
  end

  // ---------------- stage 4: dividend and divisor ----------------
  logic           v4;
  logic [N_W-1:0] n4;
  logic [D_W-1:0] d4;
  ctl_t           ctl4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (isa3) begin
        n4 <= N_W'(moh3) << SHA;
        d4 <= D_W'(mzk3);
      end else begin
        n4 <= N_W'(plo3) + (N_W'(phi3) << 32);
        d4 <= D_W'(vp_h) << SHB;
      end
      ctl4 <= ctl3;
    end
  end

  // ---------------- divider pipeline ----------------
  // Entry 0 holds the overflow check and initial remainder; entry k+1 has
  // k+1 quotient bits resolved.
  logic [Q_W:0]   dv_v;
  logic [D_W-1:0] dv_rem [Q_W+1];
  logic [D_W-1:0] dv_d   [Q_W+1];
  logic [Q_W-1:0] dv_q   [Q_W+1];
  logic [Q_W-1:0] dv_nlo [Q_W+1];
  logic           dv_ovf [Q_W+1];
  ctl_t           dv_ctl [Q_W+1];

  logic [NH_W-1:0] nh4;
  assign nh4 = n4[N_W-1:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ovf[0] <= (nh4 >= d4);
      dv_rem[0] <= D_W'(nh4);
      dv_d[0]   <= d4;
      dv_q[0]   <= '0;
      dv_nlo[0] <= n4[Q_W-1:0];
      dv_ctl[0] <= ctl4;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [D_W:0] rem2;
    logic         ge;

    // one restoring step: bring down a dividend bit, subtract if it fits
    assign rem2 = {dv_rem[k], dv_nlo[k][Q_W-1]};
    assign ge   = (rem2 >= {1'b0, dv_d[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k+1] <= ge ? D_W'(rem2 - {1'b0, dv_d[k]}) : D_W'(rem2);
        dv_q[k+1]   <= {dv_q[k][Q_W-2:0], ge};
        dv_nlo[k+1] <= dv_nlo[k] << 1;
        dv_d[k+1]   <= dv_d[k];
        dv_ovf[k+1] <= dv_ovf[k];
        dv_ctl[k+1] <= dv_ctl[k];
      end
    end
  end

  // ---------------- final stage: offset, sign, saturation ----------------
  logic signed [RES_W-1:0] term, sum;
  logic [VAL_W-1:0]        res_c;
  logic                    err_c;
  ctl_t                    cf;

  always_comb begin
    cf   = dv_ctl[Q_W];
    term = cf.tneg ? -signed'(RES_W'(dv_q[Q_W])) : signed'(RES_W'(dv_q[Q_W]));
    sum  = signed'(RES_W'(cf.base)) + term;
    priority if (cf.sp) begin
      res_c = '0;
      err_c = 1'b1;
    end else if (dv_ovf[Q_W]) begin
      res_c = cf.tneg ? VAL_W'(SAT_LO) : VAL_W'(SAT_HI);
      err_c = 1'b1;
    end else if (sum > SAT_HI) begin
      res_c = VAL_W'(SAT_HI);
      err_c = 1'b1;
    end else if (sum < SAT_LO) begin
      res_c = VAL_W'(SAT_LO);
      err_c = 1'b1;
    end else begin
      res_c = sum[VAL_W-1:0];
      err_c = 1'b0;
    end
  end

  logic [VAL_W-1:0] out_res;
  logic             out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res_c;
      out_err <= err_c;
    end
  end

  assign out_ch.valid  = out_v;
  assign out_ch.result = out_res;
  assign out_ch.error  = out_err;

  // ---------------- assertions ----------------
  logic [Q_W+5:0] vbits;
  assign vbits = {v1, v2, v3, v4, dv_v, out_v};

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vbits))
    else $error("pipeline valid bits moved during a stall");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dv_v[Q_W] && !dv_ovf[Q_W] && !dv_ctl[Q_W].sp |-> dv_rem[Q_W] < dv_d[Q_W])
    else $error("divider remainder not below divisor");

  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && (in_ch.depth_z == '0) |=> v1 && ctl1.sp)
    else $error("zero depth item not flagged");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_v && (vbits == '0))
    else $error("pipeline not empty after reset");

endmodule

/* bench/perspective_screen_mapper_top_tb.sv */
// Testbench: checks the perspective screen mapper against a built-in bit-exact predictor.
`timescale 1ns / 1ps
module perspective_screen_mapper_top_tb;
  import psm_pkg::*;

  localparam logic [2:0] FN_RSVD_6 = 3'd6;
  localparam logic [2:0] FN_RSVD_7 = 3'd7;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;

  typedef struct {
    logic [31:0] result;
    logic        error;
  } mapped_t;

  // Scoreboard: viewport copy, conversion predictor and pending results
  class mapping_scoreboard;
    logic [CFG_W-1:0] vp_w = VP_W_RST;
    logic [CFG_W-1:0] vp_h = VP_H_RST;
    mapped_t          pending_q[$];
    int               fails = 0;

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      if (idx == REG_WIDTH) vp_w = val[CFG_W-1:0];
      else vp_h = val[CFG_W-1:0];
    endfunction

    // Work out the mapped coordinate for one accepted item
    function void note_input(logic [2:0] fn, logic [31:0] op, logic [31:0] dz);
      bit so, sz, sa, err;
      logic [31:0] mo, mz;
      logic [63:0] mzk, ma, c;
      logic [127:0] num, q, prod;
      longint res, term, base, os, a;
      mapped_t e;
      so = op[31];
      sz = dz[31];
      mo = so ? -op : op;
      mz = sz ? -dz : dz;
      mzk = 64'(mz) * 64'(K_Q32);
      err = 0;
      res = 0;
      if (fn > FN_WIDTH || dz == 0) begin
        err = 1;
      end else if (fn == FN_X_TO_SCR || fn == FN_Y_TO_SCR) begin
        c = (fn == FN_X_TO_SCR) ? 64'(vp_w) : 64'(vp_h);
        base = longint'(c << (FRAC_BITS - 1));
        num = (128'(mo) * 128'(vp_h)) << (31 + FRAC_BITS);
        q = num / 128'(mzk);
        if (q >= (128'd1 << 40)) begin
          q = 128'd1 << 40;
          err = 1;
        end
        term = (so != sz) ? -longint'(q[63:0]) : longint'(q[63:0]);
        res = (fn == FN_X_TO_SCR) ? base + term : base - term;
      end else if (vp_h == 0) begin
        err = 1;
      end else begin
        c = (fn == FN_SCR_TO_X) ? 64'(vp_w) : (fn == FN_SCR_TO_Y) ? 64'(vp_h) : 64'd0;
        os = so ? -longint'(mo) : longint'(mo);
        a = 2 * os - longint'(c << FRAC_BITS);
        sa = a < 0;
        ma = sa ? 64'(-a) : 64'(a);
        prod = (128'(ma) * 128'(mzk)) >> (32 + FRAC_BITS);
        q = prod / 128'(vp_h);
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        res = (sa != sz) ? -longint'(q[63:0]) : longint'(q[63:0]);
      end
      // saturate to the Q16.16 range
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        err = 1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        err = 1;
      end
      e.result = res[31:0];
      e.error  = err;
      pending_q.push_back(e);
    endfunction

    function void check(logic [31:0] res, logic err);
      mapped_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: result=%h error=%b", res, err);
        fails++;
        return;
      end
      e = pending_q.pop_front();
      if (res !== e.result) begin
        $error("result mismatch: expected %h actual %h", e.result, res);
        fails++;
      end
      if (err !== e.error) begin
        $error("error mismatch: expected %b actual %b", e.error, err);
        fails++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  psm_in_if  in_ch ();
  psm_out_if out_ch ();

  perspective_screen_mapper_top DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  mapping_scoreboard sb = new();
  bit hold_req = 0;
  bit sending  = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int wait_left;
    wait_left = 0;
    out_ch.ready <= 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        sb.check(out_ch.result, out_ch.error);
        wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      end
      if (hold_req) begin
        hold_req = 0;
        wait_left = 400;
      end
      if (wait_left > 0) begin
        wait_left--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // One input transfer after a random gap
  task automatic send_item(logic [2:0] fn, logic [31:0] op, logic [31:0] dz);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid   <= 1;
    in_ch.func    <= fn;
    in_ch.operand <= op;
    in_ch.depth_z <= dz;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(fn, op, dz);
  endtask

  task automatic end_burst();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  // Register write: setup then access cycle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Let every result drain, then allow for pipeline latency
  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'($urandom_range(0, 3));
      2:       return -32'($urandom_range(1, 200) << 16);
      3:       return 32'($urandom_range(1, 65535));
      default: return 32'($urandom_range(1, 1000)) * ONE_Q + 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] rand_operand(logic [2:0] fn);
    case ($urandom_range(0, 7))
      0, 1: return $urandom();
      2:    return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      3:    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        // screen side coordinates in pixels up to 20000, view side within +-1000 units
        if (fn == FN_X_TO_SCR || fn == FN_Y_TO_SCR)
          return 32'($signed($urandom_range(0, 2000)) - 1000) * ONE_Q + 32'($urandom_range(0, 65535));
        return 32'($urandom_range(0, 20000)) * ONE_Q + 32'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  task automatic random_items(int count);
    logic [2:0] fn;
    repeat (count) begin
      fn = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_item(fn, rand_operand(fn), rand_depth());
    end
    end_burst();
  endtask

  initial begin
    logic [31:0] ops[4];
    logic [31:0] dzs[4];
    in_ch.valid   <= 0;
    in_ch.func    <= FN_X_TO_SCR;
    in_ch.operand <= 0;
    in_ch.depth_z <= 0;
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    paddr   <= 0;
    pwdata  <= 0;
    rst     <= 1;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every func over operand and depth extremes, depth zero, reserved codes
    ops = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    dzs = '{ONE_Q, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    for (int f = 0; f < 6; f++) begin
      send_item(3'(f), ops[f % 4], dzs[f % 4]);
      send_item(3'(f), ops[(f + 1) % 4], dzs[(f + 2) % 4]);
      send_item(3'(f), 32'd100 << 16, 32'h0);
    end
    send_item(FN_RSVD_6, ONE_Q, ONE_Q);
    send_item(FN_RSVD_7, ONE_Q, 32'hFFFF_FFFF);
    send_item(FN_SCR_TO_X, 32'd960 << 16, 32'd5 << 16);
    send_item(FN_X_TO_SCR, 32'h8000_0000, 32'hFFFF_FFFF);
    end_burst();

    // Default viewport with a long receiver hold-off to back up the pipeline
    hold_req = 1;
    random_items(140);
    drain();

    // Smallest viewport
    write_reg(REG_WIDTH, 32'd1);
    write_reg(REG_HEIGHT, 32'd1);
    random_items(140);
    drain();

    // Largest legal viewport
    write_reg(REG_WIDTH, 32'd16384);
    write_reg(REG_HEIGHT, 32'd16384);
    random_items(140);
    drain();

    // Zero height, width out of range with upper bits set
    write_reg(REG_WIDTH, 32'hFFFF_FFFF);
    write_reg(REG_HEIGHT, 32'hABCD_8000);
    random_items(120);
    drain();

    // Random settings
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_WIDTH, $urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(1, 16384));
      write_reg(REG_HEIGHT, $urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(1, 16384));
      random_items(100);
      drain();
    end

    if (sb.pending_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_q.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
